// ===== sv/pcn_pkg.sv =====
// Shared types and constants of the pick cluster nucleator.
// Used by the channel interfaces, the register block, controller and datapath.
package pcn_pkg;

	localparam int DEPTH_DEF = 64;

	// field widths
	localparam int TIME_W  = 48;
	localparam int TT_W    = 22;
	localparam int PID_W   = 16;
	localparam int STA_W   = 12;
	localparam int AZ_W    = 16;
	localparam int SLOW_W  = 15;
	localparam int DIST_W  = 15;
	localparam int RES_W   = 21;
	localparam int CNT_W   = 7;
	localparam int RAD_W   = 12;
	localparam int WIN_W   = 20;
	localparam int MINP_W  = 7;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// arithmetic constants
	localparam int AZ_FULL   = 36000;
	localparam int AZ_HALF   = 18000;
	localparam int TOL_BIAS  = 589824000;	// 4000 ms * 147456
	localparam int PKP_MS    = 960000;
	localparam int RES_LIMIT = 1000000;
	localparam int OUT_LIMIT = 64;
	localparam int CNT_SAT   = 127;

	// register map
	localparam logic [1:0] REG_RADIUS = 2'd0;
	localparam logic [1:0] REG_WINDOW = 2'd1;
	localparam logic [1:0] REG_MAXD   = 2'd2;
	localparam logic [1:0] REG_MINP   = 2'd3;

	localparam logic [RAD_W-1:0]  RADIUS_RST = 12'd64;
	localparam logic [WIN_W-1:0]  WINDOW_RST = 20'd50000;
	localparam logic [DIST_W-1:0] MAXD_RST   = 15'd18000;
	localparam logic [MINP_W-1:0] MINP_RST   = 7'd6;

	localparam logic CMD_FEED  = 1'b0;
	localparam logic CMD_CLEAN = 1'b1;
	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	typedef struct packed {
		logic [TIME_W-1:0] proj;
		logic [TIME_W-1:0] abs_t;
		logic [PID_W-1:0]  pid;
		logic [STA_W-1:0]  sta;
		logic [AZ_W-1:0]   az;
		logic [SLOW_W-1:0] slow;
	} rec_t;

	typedef struct packed {
		logic in_ready;
		logic rd_a_en;
		logic rd_b_en;
		logic wr_en;
		logic wr_new;
		logic acc_clr;
		logic row_ld;
		logic pair_go;
		logic pair_tag;
		logic best_upd;
		logic out_ld;
		logic out_kind;
		logic out_last;
	} cmd_t;

	typedef struct packed {
		logic take;
		logic clean;
		logic rej;
		logic a_le_p;
		logic a_lo_ok;
		logic a_le_hi;
		logic a_le_bound;
		logic b_sta_eq;
		logic hit;
		logic out_free;
	} stat_t;

endpackage

// ===== sv/pcn_ifs.sv =====
// Valid/ready channel interfaces for pick items and result items.
// Depends on pcn_pkg for field widths.
interface pcn_pick_if import pcn_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                cmd;
	logic [PID_W-1:0]    pick_id;
	logic [STA_W-1:0]    station_id;
	logic [TIME_W-1:0]   pick_time;
	logic [TT_W-1:0]     travel_time;
	logic [AZ_W-1:0]     station_azimuth;
	logic [SLOW_W-1:0]   station_slowness;
	logic [DIST_W-1:0]   station_distance;
	logic [DIST_W-1:0]   station_max_dist;
	logic [TIME_W-1:0]   cleanup_time;

	modport source (output valid, cmd, pick_id, station_id, pick_time, travel_time,
		station_azimuth, station_slowness, station_distance, station_max_dist,
		cleanup_time, input ready);
	modport sink (input valid, cmd, pick_id, station_id, pick_time, travel_time,
		station_azimuth, station_slowness, station_distance, station_max_dist,
		cleanup_time, output ready);
endinterface

interface pcn_result_if import pcn_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     kind;
	logic [PID_W-1:0]         arrival_pick;
	logic [STA_W-1:0]         arrival_station;
	logic signed [RES_W-1:0]  residual_ms;
	logic                     is_pkp;
	logic [TIME_W-1:0]        origin_time;
	logic [CNT_W-1:0]         removed_count;
	logic                     last;

	modport source (output valid, kind, arrival_pick, arrival_station, residual_ms,
		is_pkp, origin_time, removed_count, last, input ready);
	modport sink (input valid, kind, arrival_pick, arrival_station, residual_ms,
		is_pkp, origin_time, removed_count, last, output ready);
endinterface

// ===== sv/pcn_regs.sv =====
// APB-style configuration registers of the pick cluster nucleator.
// Depends on pcn_pkg for the register map and reset values.
module pcn_regs import pcn_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [PDATA_W-1:0]   pwdata,
	output logic [PDATA_W-1:0]   prdata,
	output logic                 pready,
	output logic [RAD_W-1:0]     radius,
	output logic [WIN_W-1:0]     win_half,
	output logic [DIST_W-1:0]    max_dist,
	output logic [MINP_W-1:0]    min_picks
);
	logic       wr;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius    <= RADIUS_RST;
			win_half  <= WINDOW_RST;
			max_dist  <= MAXD_RST;
			min_picks <= MINP_RST;
		end else if (wr) begin
			case (idx)
				REG_RADIUS: radius    <= pwdata[RAD_W-1:0];
				REG_WINDOW: win_half  <= pwdata[WIN_W-1:0];
				REG_MAXD:   max_dist  <= pwdata[DIST_W-1:0];
				REG_MINP:   min_picks <= pwdata[MINP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RADIUS: prdata = PDATA_W'(radius);
			REG_WINDOW: prdata = PDATA_W'(win_half);
			REG_MAXD:   prdata = PDATA_W'(max_dist);
			REG_MINP:   prdata = PDATA_W'(min_picks);
			default:    prdata = '0;
		endcase
	end
endmodule

// ===== sv/pcn_dp.sv =====
// Datapath: pick store memory, pair tolerance pipeline, window compares, result register.
// Depends on pcn_pkg and the channel interfaces; driven by pcn_ctrl.
module pcn_dp import pcn_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pcn_pick_if.sink                          picks,
	pcn_result_if.source                      results,
	input  logic [RAD_W-1:0]                  radius,
	input  logic [WIN_W-1:0]                  win_half,
	input  logic [DIST_W-1:0]                 max_dist,
	input  cmd_t                              cmd,
	input  logic [$clog2(STORE_DEPTH)-1:0]    a_addr,
	input  logic [$clog2(STORE_DEPTH)-1:0]    b_addr,
	input  logic [$clog2(STORE_DEPTH)-1:0]    w_addr,
	input  logic [CNT_W-1:0]                  removed,
	output stat_t                             st,
	output logic [$clog2(STORE_DEPTH+1)-1:0]  acc
);
	localparam int CW = $clog2(STORE_DEPTH+1);

	rec_t mem [STORE_DEPTH];
	rec_t a_q, b_q, row_q, new_q;
	logic [TIME_W-1:0] bound_q, otime_q;
	logic [DIST_W-1:0] dist_q, smax_q;
	logic              clean_q;

	// input capture
	logic [TIME_W-1:0] p_in;
	logic [AZ_W-1:0]   az_in;

	assign picks.ready = cmd.in_ready;
	assign st.take     = picks.valid & cmd.in_ready;

	always_comb begin
		if (TIME_W'(picks.travel_time) > picks.pick_time)
			p_in = '0;
		else
			p_in = picks.pick_time - TIME_W'(picks.travel_time);
		if (picks.station_azimuth >= AZ_W'(AZ_FULL))
			az_in = picks.station_azimuth - AZ_W'(AZ_FULL);
		else
			az_in = picks.station_azimuth;
	end

	always_ff @(posedge clk) begin
		if (st.take) begin
			new_q.proj  <= p_in;
			new_q.abs_t <= picks.pick_time;
			new_q.pid   <= picks.pick_id;
			new_q.sta   <= picks.station_id;
			new_q.az    <= az_in;
			new_q.slow  <= picks.station_slowness;
			dist_q      <= picks.station_distance;
			smax_q      <= picks.station_max_dist;
			bound_q     <= picks.cleanup_time;
			clean_q     <= picks.cmd;
		end
	end

	assign st.clean = (clean_q == CMD_CLEAN);
	assign st.rej   = (dist_q > max_dist) || (dist_q > smax_q);

	// store memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.wr_en)
			mem[w_addr] <= cmd.wr_new ? new_q : a_q;
		if (cmd.rd_a_en)
			a_q <= mem[a_addr];
		if (cmd.rd_b_en)
			b_q <= mem[b_addr];
		if (cmd.row_ld)
			row_q <= a_q;
		if (cmd.best_upd)
			otime_q <= row_q.proj;
	end

	// window and scan compares
	logic [TIME_W:0] p_plus_w, a_plus_w;
	assign p_plus_w      = {1'b0, new_q.proj} + (TIME_W+1)'(win_half);
	assign a_plus_w      = {1'b0, a_q.proj} + (TIME_W+1)'(win_half);
	assign st.a_le_p     = a_q.proj <= new_q.proj;
	assign st.a_lo_ok    = a_plus_w >= {1'b0, new_q.proj};
	assign st.a_le_hi    = {1'b0, a_q.proj} <= p_plus_w;
	assign st.a_le_bound = a_q.proj <= bound_q;
	assign st.b_sta_eq   = b_q.sta == row_q.sta;

	// pair tolerance pipeline
	logic              v_b_q, tag_b_q;
	logic              v_s1, tag_s1, big_s1;
	logic [31:0]       dt_s1;
	logic [14:0]       ad_s1;
	logic [27:0]       rs_s1;
	logic              v_s2, tag_s2, big_s2;
	logic [42:0]       prod_s2;
	logic [49:0]       dtx_s2;
	logic              hit_q;
	logic [CW-1:0]     acc_q;

	logic [TIME_W-1:0] dt;
	logic [AZ_W-1:0]   adr;
	logic [14:0]       ad;
	logic [35:0]       dt9;
	logic              pass;

	always_comb begin
		dt  = (row_q.proj >= b_q.proj) ? row_q.proj - b_q.proj : b_q.proj - row_q.proj;
		adr = (row_q.az >= b_q.az) ? row_q.az - b_q.az : b_q.az - row_q.az;
		// fold the azimuth difference to a true angle
		if (adr > AZ_W'(AZ_HALF))
			ad = 15'(AZ_W'(AZ_FULL) - adr);
		else
			ad = adr[14:0];
		dt9  = {dt_s1, 3'b000} + 36'(dt_s1);
		pass = !big_s2 && (dtx_s2 < (50'(prod_s2) + 50'(TOL_BIAS)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			hit_q <= 1'b0;
			acc_q <= '0;
		end else begin
			v_b_q <= cmd.pair_go;
			v_s1  <= v_b_q;
			v_s2  <= v_s1;
			if (cmd.acc_clr) begin
				acc_q <= '0;
				hit_q <= 1'b0;
			end else if (v_s2 && pass) begin
				acc_q <= acc_q + CW'(1);
				hit_q <= hit_q | tag_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_b_q <= cmd.pair_tag;
		tag_s1  <= tag_b_q;
		big_s1  <= |dt[TIME_W-1:32];
		dt_s1   <= dt[31:0];
		ad_s1   <= ad;
		rs_s1   <= 28'(radius) * 28'({1'b0, row_q.slow} + {1'b0, b_q.slow});
		tag_s2  <= tag_s1;
		big_s2  <= big_s1;
		prod_s2 <= 43'(rs_s1) * 43'(ad_s1);
		dtx_s2  <= {dt9, 14'd0};
	end

	assign st.hit = hit_q;
	assign acc    = acc_q;

	// result register
	logic                    out_v_q;
	logic signed [TIME_W:0]  res_d, pkp_d;
	logic signed [RES_W-1:0] res_sat;

	always_comb begin
		res_d = $signed({1'b0, a_q.proj}) - $signed({1'b0, otime_q});
		pkp_d = $signed({1'b0, a_q.abs_t}) - $signed({1'b0, otime_q});
		if (res_d > $signed((TIME_W+1)'(RES_LIMIT)))
			res_sat = RES_W'(RES_LIMIT);
		else if (res_d < -$signed((TIME_W+1)'(RES_LIMIT)))
			res_sat = -RES_W'(RES_LIMIT);
		else
			res_sat = res_d[RES_W-1:0];
	end

	assign st.out_free = !out_v_q || results.ready;
	assign results.valid = out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cmd.out_ld)
			out_v_q <= 1'b1;
		else if (results.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			results.kind <= cmd.out_kind;
			results.last <= cmd.out_last;
			if (cmd.out_kind == KIND_REPORT) begin
				results.arrival_pick    <= '0;
				results.arrival_station <= '0;
				results.residual_ms     <= '0;
				results.is_pkp          <= 1'b0;
				results.origin_time     <= '0;
				results.removed_count   <= removed;
			end else begin
				results.arrival_pick    <= a_q.pid;
				results.arrival_station <= a_q.sta;
				results.residual_ms     <= res_sat;
				results.is_pkp          <= pkp_d >= $signed((TIME_W+1)'(PKP_MS));
				results.origin_time     <= otime_q;
				results.removed_count   <= '0;
			end
		end
	end
endmodule

// ===== sv/pcn_ctrl.sv =====
// Controller: sequences store moves, window scans, pair pass, dedup and emission.
// Depends on pcn_pkg; drives pcn_dp through cmd_t and reads stat_t.
module pcn_ctrl import pcn_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [MINP_W-1:0]                 min_picks,
	input  stat_t                             st,
	input  logic [$clog2(STORE_DEPTH+1)-1:0]  acc,
	output cmd_t                              cmd,
	output logic [$clog2(STORE_DEPTH)-1:0]    a_addr,
	output logic [$clog2(STORE_DEPTH)-1:0]    b_addr,
	output logic [$clog2(STORE_DEPTH)-1:0]    w_addr,
	output logic [CNT_W-1:0]                  removed
);
	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH+1);
	localparam int MW = (CW > MINP_W) ? CW : MINP_W;
	localparam logic [1:0] PIPE_LAT = 2'd3;

	localparam logic [4:0] S_IDLE = 5'd0,  S_CHECK = 5'd1,  S_CL_RD = 5'd2,
		S_CL_CMP = 5'd3,  S_MV_RD = 5'd4,  S_MV_WR = 5'd5,  S_REPORT = 5'd6,
		S_POS_RD = 5'd7,  S_POS_CMP = 5'd8, S_MU_RD = 5'd9,  S_MU_WR = 5'd10,
		S_INS = 5'd11,    S_LO_RD = 5'd12, S_LO_CMP = 5'd13, S_HI_RD = 5'd14,
		S_HI_CMP = 5'd15, S_WIN = 5'd16,   S_PR_RD = 5'd17,  S_PR_LD = 5'd18,
		S_PR_K = 5'd19,   S_PR_DRAIN = 5'd20, S_PR_CMT = 5'd21, S_DD_ROW = 5'd22,
		S_DD_LD = 5'd23,  S_DD_K = 5'd24,  S_DD_WAIT = 5'd25, S_DD_CMT = 5'd26,
		S_EM_CHK = 5'd27, S_EM_PUT = 5'd28;

	logic [4:0]          state_q;
	logic [CW-1:0]       n_q, j_q, sh_q, pos_q, lo_q, hi_q, i_q, k_q, cnt_q;
	logic [CW-1:0]       nflag_q, narr_q, cntmax_q;
	logic [MW-1:0]       nres_q;
	logic [1:0]          drain_q;
	logic                dup_q, dd_v_q;
	logic [STORE_DEPTH-1:0] flag_q;

	logic [MW-1:0] lim, cnt_m;
	logic          flag_i, flag_k;

	assign flag_i = flag_q[i_q[IW-1:0]];
	assign flag_k = flag_q[k_q[IW-1:0]];
	assign cnt_m  = MW'(cnt_q);
	assign removed = (cnt_m > MW'(CNT_SAT)) ? CNT_W'(CNT_SAT) : cnt_m[CNT_W-1:0];
	assign lim = (MW'(narr_q) > MW'(OUT_LIMIT)) ? MW'(OUT_LIMIT) : MW'(narr_q);

	always_comb begin
		cmd    = '0;
		a_addr = '0;
		b_addr = k_q[IW-1:0];
		w_addr = '0;
		case (state_q)
			S_IDLE: cmd.in_ready = 1'b1;
			S_CL_RD: begin
				cmd.rd_a_en = cnt_q < n_q;
				a_addr = cnt_q[IW-1:0];
			end
			S_MV_RD: begin
				cmd.rd_a_en = j_q < n_q;
				a_addr = j_q[IW-1:0];
			end
			S_MV_WR: begin
				cmd.wr_en = 1'b1;
				w_addr = IW'(j_q - sh_q);
			end
			S_POS_RD: begin
				cmd.rd_a_en = pos_q < n_q;
				a_addr = pos_q[IW-1:0];
			end
			S_MU_RD: begin
				cmd.rd_a_en = j_q > pos_q;
				a_addr = IW'(j_q - CW'(1));
			end
			S_MU_WR: begin
				cmd.wr_en = 1'b1;
				w_addr = j_q[IW-1:0];
			end
			S_INS: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_new = 1'b1;
				w_addr = pos_q[IW-1:0];
			end
			S_LO_RD: begin
				cmd.rd_a_en = lo_q != '0;
				a_addr = IW'(lo_q - CW'(1));
			end
			S_HI_RD: begin
				cmd.rd_a_en = hi_q < n_q;
				a_addr = hi_q[IW-1:0];
			end
			S_PR_RD: begin
				cmd.rd_a_en = i_q < hi_q;
				cmd.acc_clr = 1'b1;
				a_addr = i_q[IW-1:0];
			end
			S_PR_LD: cmd.row_ld = 1'b1;
			S_PR_K: begin
				cmd.rd_b_en  = 1'b1;
				cmd.pair_go  = 1'b1;
				cmd.pair_tag = k_q == pos_q;
			end
			S_PR_CMT: cmd.best_upd = st.hit && (acc > cntmax_q);
			S_DD_ROW: begin
				cmd.rd_a_en = (i_q < hi_q) && flag_i;
				a_addr = i_q[IW-1:0];
			end
			S_DD_LD: cmd.row_ld = 1'b1;
			S_DD_K: cmd.rd_b_en = 1'b1;
			S_REPORT: begin
				cmd.out_ld   = st.out_free;
				cmd.out_kind = KIND_REPORT;
				cmd.out_last = 1'b1;
			end
			S_EM_CHK: begin
				cmd.rd_a_en = (nres_q != lim) && (i_q < hi_q) && flag_i;
				a_addr = i_q[IW-1:0];
			end
			S_EM_PUT: begin
				cmd.out_ld   = st.out_free;
				cmd.out_kind = KIND_ARRIVAL;
				cmd.out_last = (nres_q + MW'(1)) == lim;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			n_q      <= '0;
			j_q      <= '0;
			sh_q     <= '0;
			pos_q    <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			i_q      <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			nflag_q  <= '0;
			narr_q   <= '0;
			cntmax_q <= '0;
			nres_q   <= '0;
			drain_q  <= '0;
			dup_q    <= 1'b0;
			dd_v_q   <= 1'b0;
			flag_q   <= '0;
		end else begin
			// station match of the previous dedup probe
			dd_v_q <= (state_q == S_DD_K) && flag_k;
			if (dd_v_q && st.b_sta_eq)
				dup_q <= 1'b1;
			case (state_q)
				S_IDLE: if (st.take) state_q <= S_CHECK;
				S_CHECK: begin
					if (st.clean) begin
						cnt_q   <= '0;
						state_q <= S_CL_RD;
					end else if (st.rej) begin
						state_q <= S_IDLE;
					end else if (n_q == CW'(STORE_DEPTH)) begin
						// full: drop the oldest entry first
						sh_q    <= CW'(1);
						j_q     <= CW'(1);
						state_q <= S_MV_RD;
					end else begin
						pos_q   <= '0;
						state_q <= S_POS_RD;
					end
				end
				S_CL_RD: begin
					if (cnt_q < n_q) begin
						state_q <= S_CL_CMP;
					end else begin
						sh_q    <= cnt_q;
						j_q     <= cnt_q;
						state_q <= S_MV_RD;
					end
				end
				S_CL_CMP: begin
					if (st.a_le_bound) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= S_CL_RD;
					end else begin
						sh_q    <= cnt_q;
						j_q     <= cnt_q;
						state_q <= S_MV_RD;
					end
				end
				S_MV_RD: begin
					if (j_q < n_q) begin
						state_q <= S_MV_WR;
					end else begin
						n_q <= n_q - sh_q;
						pos_q <= '0;
						state_q <= st.clean ? S_REPORT : S_POS_RD;
					end
				end
				S_MV_WR: begin
					j_q     <= j_q + CW'(1);
					state_q <= S_MV_RD;
				end
				S_REPORT: if (st.out_free) state_q <= S_IDLE;
				S_POS_RD: begin
					if (pos_q < n_q) begin
						state_q <= S_POS_CMP;
					end else begin
						j_q     <= n_q;
						state_q <= S_MU_RD;
					end
				end
				S_POS_CMP: begin
					if (st.a_le_p) begin
						pos_q   <= pos_q + CW'(1);
						state_q <= S_POS_RD;
					end else begin
						j_q     <= n_q;
						state_q <= S_MU_RD;
					end
				end
				S_MU_RD: state_q <= (j_q > pos_q) ? S_MU_WR : S_INS;
				S_MU_WR: begin
					j_q     <= j_q - CW'(1);
					state_q <= S_MU_RD;
				end
				S_INS: begin
					n_q     <= n_q + CW'(1);
					lo_q    <= pos_q;
					state_q <= S_LO_RD;
				end
				S_LO_RD: begin
					if (lo_q != '0) begin
						state_q <= S_LO_CMP;
					end else begin
						hi_q    <= pos_q + CW'(1);
						state_q <= S_HI_RD;
					end
				end
				S_LO_CMP: begin
					if (st.a_lo_ok) begin
						lo_q    <= lo_q - CW'(1);
						state_q <= S_LO_RD;
					end else begin
						hi_q    <= pos_q + CW'(1);
						state_q <= S_HI_RD;
					end
				end
				S_HI_RD: state_q <= (hi_q < n_q) ? S_HI_CMP : S_WIN;
				S_HI_CMP: begin
					if (st.a_le_hi) begin
						hi_q    <= hi_q + CW'(1);
						state_q <= S_HI_RD;
					end else begin
						state_q <= S_WIN;
					end
				end
				S_WIN: begin
					if (MW'(hi_q - lo_q) < MW'(min_picks)) begin
						state_q <= S_IDLE;
					end else begin
						i_q      <= lo_q;
						nflag_q  <= '0;
						cntmax_q <= '0;
						state_q  <= S_PR_RD;
					end
				end
				S_PR_RD: begin
					if (i_q < hi_q) begin
						state_q <= S_PR_LD;
					end else if (MW'(nflag_q) < MW'(min_picks)) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= lo_q;
						narr_q  <= '0;
						state_q <= S_DD_ROW;
					end
				end
				S_PR_LD: begin
					k_q     <= lo_q;
					state_q <= S_PR_K;
				end
				S_PR_K: begin
					if (k_q == hi_q - CW'(1)) begin
						drain_q <= '0;
						state_q <= S_PR_DRAIN;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_PR_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == PIPE_LAT - 2'd1)
						state_q <= S_PR_CMT;
				end
				S_PR_CMT: begin
					flag_q[i_q[IW-1:0]] <= st.hit;
					if (st.hit) begin
						nflag_q <= nflag_q + CW'(1);
						if (acc > cntmax_q)
							cntmax_q <= acc;
					end
					i_q     <= i_q + CW'(1);
					state_q <= S_PR_RD;
				end
				S_DD_ROW: begin
					if (i_q < hi_q) begin
						if (flag_i)
							state_q <= S_DD_LD;
						else
							i_q <= i_q + CW'(1);
					end else if (MW'(narr_q) < MW'(min_picks)) begin
						state_q <= S_IDLE;
					end else begin
						i_q     <= lo_q;
						nres_q  <= '0;
						state_q <= S_EM_CHK;
					end
				end
				S_DD_LD: begin
					k_q     <= lo_q;
					dup_q   <= 1'b0;
					state_q <= (i_q == lo_q) ? S_DD_CMT : S_DD_K;
				end
				S_DD_K: begin
					if (k_q == i_q - CW'(1))
						state_q <= S_DD_WAIT;
					else
						k_q <= k_q + CW'(1);
				end
				S_DD_WAIT: state_q <= S_DD_CMT;
				S_DD_CMT: begin
					if (dup_q)
						flag_q[i_q[IW-1:0]] <= 1'b0;
					else
						narr_q <= narr_q + CW'(1);
					i_q     <= i_q + CW'(1);
					state_q <= S_DD_ROW;
				end
				S_EM_CHK: begin
					if ((nres_q == lim) || (i_q >= hi_q))
						state_q <= S_IDLE;
					else if (flag_i)
						state_q <= S_EM_PUT;
					else
						i_q <= i_q + CW'(1);
				end
				S_EM_PUT: begin
					if (st.out_free) begin
						nres_q  <= nres_q + MW'(1);
						i_q     <= i_q + CW'(1);
						state_q <= S_EM_CHK;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== sv/pick_cluster_nucleator.sv =====
// Pick cluster nucleator: one grid point's pick store with cluster detection.
// Per pick: store moves and window scans, then the pair pass and the station dedup over the
// picks in the window. The worst case is set by the single pair pipeline; one item at a time.
// Cleanup: scans the oldest entries, moves the rest down and reports the removed count.
// Arrivals leave one by one while results are taken.
// Reset: store empty (count cleared), registers at reset values, no clearing pass.
module pick_cluster_nucleator import pcn_pkg::*; #(
	parameter int STORE_DEPTH = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	pcn_pick_if.sink            picks,
	pcn_result_if.source        results,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);
	localparam int IW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH+1);

	logic [RAD_W-1:0]  radius;
	logic [WIN_W-1:0]  win_half;
	logic [DIST_W-1:0] max_dist;
	logic [MINP_W-1:0] min_picks;
	cmd_t              cmd;
	stat_t             st;
	logic [IW-1:0]     a_addr, b_addr, w_addr;
	logic [CW-1:0]     acc;
	logic [CNT_W-1:0]  removed;

	pcn_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.radius, .win_half, .max_dist, .min_picks
	);

	pcn_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
		.clk, .arst_n, .min_picks, .st, .acc, .cmd, .a_addr, .b_addr, .w_addr, .removed
	);

	pcn_dp #(.STORE_DEPTH(STORE_DEPTH)) u_dp (
		.clk, .arst_n, .picks, .results, .radius, .win_half, .max_dist,
		.cmd, .a_addr, .b_addr, .w_addr, .removed, .st, .acc
	);
endmodule

// ===== tb/pick_cluster_nucleator_test.sv =====
// Self-checking test of pick_cluster_nucleator: picks, cleanups and APB register writes.
// Depends on pcn_pkg, the pcn_pick_if / pcn_result_if channels and the block itself.
`timescale 1ns / 100ps

module pick_cluster_nucleator_test;
	import pcn_pkg::*;

	localparam int HELD_MAX   = DEPTH_DEF;
	localparam int DRAIN_WAIT = 12000;
	localparam int CYCLE_CAP  = 8000000;
	localparam longint unsigned TOL_DIV = 147456;
	localparam longint unsigned MASK48  = 64'hFFFF_FFFF_FFFF;

	typedef struct {
		logic              cmd;
		logic [PID_W-1:0]  pick_id;
		logic [STA_W-1:0]  station_id;
		logic [TIME_W-1:0] pick_time;
		logic [TT_W-1:0]   travel_time;
		logic [AZ_W-1:0]   azimuth;
		logic [SLOW_W-1:0] slowness;
		logic [DIST_W-1:0] distance;
		logic [DIST_W-1:0] sta_max_dist;
		logic [TIME_W-1:0] cleanup_time;
	} pick_item_t;

	typedef struct {
		logic              kind;
		logic [PID_W-1:0]  pick_id;
		logic [STA_W-1:0]  station_id;
		logic [RES_W-1:0]  residual;
		logic              is_pkp;
		logic [TIME_W-1:0] origin;
		logic [CNT_W-1:0]  removed;
		logic              last;
	} arrival_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	pcn_pick_if   pick_ch ();
	pcn_result_if res_ch ();

	pick_cluster_nucleator dut (
		.clk(clk), .arst_n(arst_n), .picks(pick_ch), .results(res_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the pick store, kept sorted by projected time
	logic [TIME_W-1:0] held_proj [HELD_MAX];
	logic [TIME_W-1:0] held_abs [HELD_MAX];
	logic [PID_W-1:0]  held_pid [HELD_MAX];
	logic [STA_W-1:0]  held_sta [HELD_MAX];
	logic [AZ_W-1:0]   held_az [HELD_MAX];
	logic [SLOW_W-1:0] held_slow [HELD_MAX];
	int                held_cnt [HELD_MAX];
	int                n_held = 0;

	logic [RAD_W-1:0]  radius_cfg = RADIUS_RST;
	logic [WIN_W-1:0]  window_cfg = WINDOW_RST;
	logic [DIST_W-1:0] maxd_cfg = MAXD_RST;
	logic [MINP_W-1:0] minp_cfg = MINP_RST;

	pick_item_t pick_backlog[$];
	arrival_t   arrivals_due[$];
	int errors = 0, items_sent = 0, items_taken = 0, results_seen = 0;
	int origins_seen = 0, cleanups_seen = 0;
	int cycles = 0;
	logic took = 1'b0;

	task automatic queue_pick(input pick_item_t it);
		pick_backlog.insert(pick_backlog.size(), it);
	endtask

	task automatic expect_result(input arrival_t e);
		arrivals_due.insert(arrivals_due.size(), e);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
			results_seen);
	endtask

	task automatic drop_oldest(input int cnt);
		for (int i = cnt; i < n_held; i++) begin
			held_proj[i-cnt] = held_proj[i];
			held_abs[i-cnt]  = held_abs[i];
			held_pid[i-cnt]  = held_pid[i];
			held_sta[i-cnt]  = held_sta[i];
			held_az[i-cnt]   = held_az[i];
			held_slow[i-cnt] = held_slow[i];
			held_cnt[i-cnt]  = held_cnt[i];
		end
		n_held -= cnt;
	endtask

	function automatic bit pair_close(input int i, input int k);
		longint unsigned ti, tk, dt, ad, rhs;
		ti = held_proj[i];
		tk = held_proj[k];
		dt = ti >= tk ? ti - tk : tk - ti;
		ad = held_az[i] >= held_az[k] ? held_az[i] - held_az[k] : held_az[k] - held_az[i];
		if (ad > AZ_HALF)
			ad = AZ_FULL - ad;
		if (dt >= 64'h1_0000_0000)
			return 0;
		rhs = longint'(radius_cfg) * (longint'(held_slow[i]) + held_slow[k]) * ad
			+ TOL_BIAS;
		return dt * TOL_DIV < rhs;
	endfunction

	// work out the arrivals (or cleanup report) that one accepted item causes
	task automatic predict_origin(input pick_item_t it);
		longint unsigned p, otime, win;
		longint r;
		int pos, lo, hi, best, cntmax, nflag, narr, nres, cnt;
		bit flag [HELD_MAX];
		bit dup;
		arrival_t e;
		if (it.cmd == CMD_CLEAN) begin
			cnt = 0;
			while (cnt < n_held && held_proj[cnt] <= it.cleanup_time)
				cnt++;
			drop_oldest(cnt);
			e = '{default: '0};
			e.kind = KIND_REPORT;
			e.removed = CNT_W'((cnt > CNT_SAT) ? CNT_SAT : cnt);
			e.last = 1'b1;
			expect_result(e);
			return;
		end
		if (it.distance > maxd_cfg || it.distance > it.sta_max_dist)
			return;
		p = it.travel_time > it.pick_time ? 0 : it.pick_time - it.travel_time;
		if (n_held == HELD_MAX)
			drop_oldest(1);
		pos = 0;
		while (pos < n_held && held_proj[pos] <= p)
			pos++;
		for (int i = n_held; i > pos; i--) begin
			held_proj[i] = held_proj[i-1];
			held_abs[i]  = held_abs[i-1];
			held_pid[i]  = held_pid[i-1];
			held_sta[i]  = held_sta[i-1];
			held_az[i]   = held_az[i-1];
			held_slow[i] = held_slow[i-1];
			held_cnt[i]  = held_cnt[i-1];
		end
		held_proj[pos] = TIME_W'(p);
		held_abs[pos]  = it.pick_time;
		held_pid[pos]  = it.pick_id;
		held_sta[pos]  = it.station_id;
		held_az[pos]   = AZ_W'(it.azimuth % AZ_FULL);
		held_slow[pos] = it.slowness;
		held_cnt[pos]  = 0;
		n_held++;
		win = window_cfg;
		lo = pos;
		while (lo > 0 && longint'(held_proj[lo-1]) + win >= p)
			lo--;
		hi = pos + 1;
		while (hi < n_held && held_proj[hi] <= p + win)
			hi++;
		if (hi - lo < minp_cfg)
			return;
		for (int i = lo; i < hi; i++) begin
			held_cnt[i] = 0;
			flag[i] = 0;
		end
		for (int i = lo; i < hi; i++)
			for (int k = i; k < hi; k++)
				if (pair_close(i, k)) begin
					held_cnt[i]++;
					held_cnt[k]++;
					if (i == pos || k == pos) begin
						flag[i] = 1;
						flag[k] = 1;
					end
				end
		nflag = 0;
		for (int i = lo; i < hi; i++)
			nflag += flag[i];
		if (nflag < minp_cfg)
			return;
		cntmax = 0;
		best = 0;
		for (int i = lo; i < hi; i++)
			if (flag[i] && held_cnt[i] > cntmax) begin
				cntmax = held_cnt[i];
				best = i;
			end
		otime = held_proj[best];
		// keep only the earliest flagged pick of each station
		narr = 0;
		for (int i = lo; i < hi; i++) begin
			if (!flag[i])
				continue;
			dup = 0;
			for (int k = lo; k < i; k++)
				if (flag[k] && held_sta[k] == held_sta[i])
					dup = 1;
			if (dup)
				flag[i] = 0;
			else
				narr++;
		end
		if (narr < minp_cfg)
			return;
		nres = 0;
		for (int i = lo; i < hi && nres < OUT_LIMIT; i++) begin
			if (!flag[i])
				continue;
			r = longint'(held_proj[i]) - longint'(otime);
			if (r > RES_LIMIT)
				r = RES_LIMIT;
			if (r < -RES_LIMIT)
				r = -RES_LIMIT;
			e.kind = KIND_ARRIVAL;
			e.pick_id = held_pid[i];
			e.station_id = held_sta[i];
			e.residual = r[RES_W-1:0];
			e.is_pkp = (longint'(held_abs[i]) - longint'(otime)) >= PKP_MS;
			e.origin = TIME_W'(otime);
			e.removed = '0;
			e.last = 1'b0;
			expect_result(e);
			nres++;
		end
		arrivals_due[arrivals_due.size()-1].last = 1'b1;
		origins_seen++;
	endtask

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// monitor: check results first, then predict for the item taken at this edge
	always @(posedge clk) begin
		arrival_t w;
		took <= pick_ch.valid && pick_ch.ready;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (arrivals_due.size() == 0) begin
				errors++;
				$display("MISMATCH unexpected result, kind %0d", res_ch.kind);
			end else begin
				w = arrivals_due.pop_front();
				if (res_ch.kind !== w.kind)
					report_mismatch("kind", res_ch.kind, w.kind);
				if (res_ch.arrival_pick !== w.pick_id)
					report_mismatch("arrival_pick", res_ch.arrival_pick, w.pick_id);
				if (res_ch.arrival_station !== w.station_id)
					report_mismatch("arrival_station", res_ch.arrival_station, w.station_id);
				if (res_ch.residual_ms !== w.residual)
					report_mismatch("residual_ms", res_ch.residual_ms, $signed(w.residual));
				if (res_ch.is_pkp !== w.is_pkp)
					report_mismatch("is_pkp", res_ch.is_pkp, w.is_pkp);
				if (res_ch.origin_time !== w.origin)
					report_mismatch("origin_time", res_ch.origin_time, w.origin);
				if (res_ch.removed_count !== w.removed)
					report_mismatch("removed_count", res_ch.removed_count, w.removed);
				if (res_ch.last !== w.last)
					report_mismatch("last", res_ch.last, w.last);
				if (w.kind == KIND_REPORT)
					cleanups_seen++;
			end
			results_seen++;
		end
		if (arst_n && pick_ch.valid && pick_ch.ready) begin
			items_taken++;
			predict_origin('{pick_ch.cmd, pick_ch.pick_id, pick_ch.station_id,
				pick_ch.pick_time, pick_ch.travel_time, pick_ch.station_azimuth,
				pick_ch.station_slowness, pick_ch.station_distance,
				pick_ch.station_max_dist, pick_ch.cleanup_time});
		end
	end

	// driver: bursts of items with random gaps
	int burst_left = 0, gap_left = 0;
	always @(negedge clk) begin
		pick_item_t it;
		bit send;
		send = 0;
		if (!arst_n) begin
			pick_ch.valid <= 1'b0;
			pick_ch.cmd <= CMD_FEED;
			pick_ch.pick_id <= '0;
			pick_ch.station_id <= '0;
			pick_ch.pick_time <= '0;
			pick_ch.travel_time <= '0;
			pick_ch.station_azimuth <= '0;
			pick_ch.station_slowness <= '0;
			pick_ch.station_distance <= '0;
			pick_ch.station_max_dist <= '0;
			pick_ch.cleanup_time <= '0;
		end else if (!(pick_ch.valid && !took)) begin
			// a waiting item is held; otherwise pick the next one
			if (gap_left > 0) begin
				gap_left--;
			end else if (pick_backlog.size() > 0) begin
				it = pick_backlog.pop_front();
				send = 1;
				items_sent++;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 20);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			pick_ch.valid <= send;
			if (send) begin
				pick_ch.cmd <= it.cmd;
				pick_ch.pick_id <= it.pick_id;
				pick_ch.station_id <= it.station_id;
				pick_ch.pick_time <= it.pick_time;
				pick_ch.travel_time <= it.travel_time;
				pick_ch.station_azimuth <= it.azimuth;
				pick_ch.station_slowness <= it.slowness;
				pick_ch.station_distance <= it.distance;
				pick_ch.station_max_dist <= it.sta_max_dist;
				pick_ch.cleanup_time <= it.cleanup_time;
			end
		end
	end

	// receiver: stall pattern redrawn whenever the low byte of the cycle count is zero, sometimes no stall at all
	logic [15:0] stall_pat = 16'hFFFF;
	always @(negedge clk) begin
		if (cycles[7:0] == 0)
			stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		res_ch.ready <= arst_n & stall_pat[cycles[3:0]];
	end

	function automatic pick_item_t random_item();
		pick_item_t it;
		it.cmd = ($urandom_range(0, 5) == 0) ? CMD_CLEAN : CMD_FEED;
		it.pick_id = PID_W'($urandom);
		it.station_id = STA_W'($urandom);
		it.pick_time = TIME_W'({$urandom, $urandom});
		it.travel_time = TT_W'($urandom);
		it.azimuth = AZ_W'($urandom);
		it.slowness = SLOW_W'($urandom);
		it.distance = DIST_W'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 18000));
		it.sta_max_dist = DIST_W'(($urandom_range(0, 3) == 0) ? $urandom :
			$urandom_range(0, 18000));
		it.cleanup_time = TIME_W'({$urandom, $urandom});
		return it;
	endfunction

	function automatic pick_item_t cleanup_item(input longint unsigned bound);
		pick_item_t it;
		it = random_item();
		it.cmd = CMD_CLEAN;
		it.cleanup_time = TIME_W'(bound);
		return it;
	endfunction

	// a well-formed group: picks from one origin within jit ms of each other
	task automatic add_cluster(input int k, input int jit, input bit dup_sta);
		longint unsigned origin;
		int base;
		pick_item_t it;
		origin = ({$urandom, $urandom} % 64'h8000_0000_0000) + 64'h80_0000;
		base = $urandom_range(0, 4095 - k);
		for (int j = 0; j < k; j++) begin
			it = random_item();
			it.cmd = CMD_FEED;
			it.station_id = STA_W'((dup_sta && j % 3 == 2) ? base : base + j);
			if (dup_sta && j % 4 == 3)
				it.pick_id = 16'h1234;
			it.travel_time = TT_W'($urandom_range(0, 4194303));
			it.pick_time = TIME_W'(origin + it.travel_time + $urandom_range(0, jit));
			it.azimuth = AZ_W'(($urandom_range(0, 9) == 0) ? $urandom :
				$urandom_range(0, 35999));
			it.distance = DIST_W'($urandom_range(0, maxd_cfg));
			it.sta_max_dist = DIST_W'($urandom_range(it.distance, 18000));
			queue_pick(it);
		end
	endtask

	task automatic fill_random(input int target, input int jit);
		int added, k;
		added = 0;
		while (added < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					k = minp_cfg + $urandom_range(0, 3);
					add_cluster(k, jit, $urandom_range(0, 2) == 0);
					added += k;
				end
				6: begin
					queue_pick(cleanup_item($urandom_range(0, 1) ?
						{$urandom, $urandom} : 64'h0));
					added++;
				end
				default: begin
					queue_pick(random_item());
					added++;
				end
			endcase
		end
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
		logic [PDATA_W-1:0] want;
		@(negedge clk);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_RADIUS: radius_cfg = val[RAD_W-1:0];
			REG_WINDOW: window_cfg = val[WIN_W-1:0];
			REG_MAXD:   maxd_cfg = val[DIST_W-1:0];
			default:    minp_cfg = val[MINP_W-1:0];
		endcase
		@(negedge clk);
		pwrite <= 0; penable <= 0;
		@(negedge clk);
		penable <= 1;
		@(posedge clk);
		case (idx)
			REG_RADIUS: want = PDATA_W'(radius_cfg);
			REG_WINDOW: want = PDATA_W'(window_cfg);
			REG_MAXD:   want = PDATA_W'(maxd_cfg);
			default:    want = PDATA_W'(minp_cfg);
		endcase
		if (prdata !== want)
			report_mismatch("register readback", prdata, want);
		@(negedge clk);
		psel <= 0; penable <= 0;
	endtask

	// hold until the block has gone quiet
	task automatic drain();
		while (pick_backlog.size() > 0 || pick_ch.valid || arrivals_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_regs(input int rad, input int win, input int maxd, input int minp);
		drain();
		reg_write(REG_RADIUS, rad);
		reg_write(REG_WINDOW, win);
		reg_write(REG_MAXD, maxd);
		reg_write(REG_MINP, minp);
	endtask

	initial begin
		pick_item_t it;
		arst_n = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset values, edge fields, rejections, duplicates, cleanups
		queue_pick(cleanup_item(0));
		it = random_item();
		it.cmd = CMD_FEED; it.pick_time = '0; it.travel_time = 22'd5;
		it.distance = '0; it.sta_max_dist = '0;
		queue_pick(it);
		it.pick_time = TIME_W'(MASK48); it.travel_time = '1; it.azimuth = '1;
		it.slowness = '1;
		it.distance = 15'd18000; it.sta_max_dist = 15'd18000;
		queue_pick(it);
		it.distance = 15'd500; it.sta_max_dist = 15'd400;
		queue_pick(it);
		add_cluster(8, 1500, 1);
		add_cluster(6, 0, 0);
		queue_pick(cleanup_item(0));
		queue_pick(cleanup_item(MASK48));
		fill_random(18, 3000);

		// wide window and tolerance, one pick is enough
		set_regs(4095, 1000000, 18000, 1);
		fill_random(18, 1900000);

		// narrowest settings; a full store of equal projections gives 64 arrivals
		set_regs(0, 0, 0, 64);
		queue_pick(cleanup_item(MASK48));
		add_cluster(64, 0, 0);
		repeat (4) queue_pick(random_item());
		queue_pick(cleanup_item(MASK48));

		set_regs(200, 20000, 9000, 3);
		fill_random(18, 25000);
		drain();

		$display("%0d items taken, %0d results checked: %0d origins, %0d cleanup reports",
			items_taken, results_seen, origins_seen, cleanups_seen);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
